// File: hw/rtl/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// shared sizes, table entry types and port groups of the tournament predictor
// ----------------------------------------------------------------------------
package tbp_pkg;

   localparam int TABLE_ENTRIES = 2048;
   localparam int HISTORY_BITS  = 11;
   localparam int INDEX_BITS    = $clog2(TABLE_ENTRIES);
   localparam int COUNT_BITS    = 32;

   typedef logic [INDEX_BITS-1:0]   idx_type;
   typedef logic [HISTORY_BITS-1:0] hist_type;
   typedef logic [1:0]              ctr_type;
   typedef logic [COUNT_BITS-1:0]   count_type;

   localparam idx_type   IDX_MASK  = INDEX_BITS'(TABLE_ENTRIES - 1);
   localparam idx_type   IDX_LAST  = INDEX_BITS'(TABLE_ENTRIES - 1);
   localparam count_type COUNT_MAX = '1;

   typedef struct packed {
      ctr_type chooser;
      logic    bim;
   } bim_entry_type;

   localparam bim_entry_type BIM_RESET = '{chooser: 2'd0, bim: 1'b1};
   localparam ctr_type       GSH_RESET = 2'd3;

   typedef struct packed {
      logic    en;
      idx_type bi;
      idx_type gi;
   } rd_req_type;

   typedef struct packed {
      logic          en;
      bim_entry_type bim_entry;
      ctr_type       gsh;
   } wr_req_type;

endpackage

// File: hw/rtl/tournament_branch_predictor_core.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor_core
// gshare / bimodal tournament predictor scoring a stream of resolved branches
// ----------------------------------------------------------------------------
// The req channel takes one resolved branch per word: its address and its
// actual direction. The rsp channel returns one word per branch: the chosen
// prediction made from the state before the branch, whether it was right, and
// the saturating counts of correct predictions and of branches so far.
// A result is registered: the table read happens at the accepting edge, the
// update and the output register when the read stage advances. Throughput is
// one branch per cycle unless the receiver stalls; each table memory does one
// read and one write-back per cycle, with the last write forwarded to the next
// branch. After reset a clearing pass writes the reset values into all 2048
// entries of both memories, one entry per cycle; req_ready stays low until the
// pass ends. When the receiver stalls, the output register holds its word and
// one more branch may wait in the read stage; after that req_ready drops.
// ----------------------------------------------------------------------------
module tournament_branch_predictor_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [31:0]          req_branch_address,
   input  logic                 req_actual_taken,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_predicted_taken,
   output logic                 rsp_prediction_correct,
   output tbp_pkg::count_type   rsp_correct_count,
   output tbp_pkg::count_type   rsp_branch_count
);
   import tbp_pkg::*;

   function automatic ctr_type step_ctr(input ctr_type c, input logic up);
      ctr_type r;
      r = c;
      if (up) begin
         if (c != 2'd3) r = c + 2'd1;
      end else begin
         if (c != 2'd0) r = c - 2'd1;
      end
      return r;
   endfunction

   rd_req_type    rd_req;
   wr_req_type    wr_req;
   bim_entry_type rd_bim;
   ctr_type       rd_gsh;
   logic          busy;

   hist_type      hist_ff;
   logic          s1_vld_ff;
   logic          s1_taken_ff;
   logic          rsp_valid_ff;
   logic          pred_ff;
   logic          correct_ff;
   count_type     hits_ff;
   count_type     seen_ff;

   logic          accept;
   logic          out_free;
   logic          s1_adv;
   idx_type       addr_idx;
   logic          bim_pred;
   logic          gsh_pred;
   logic          pred;
   logic          correct;
   bim_entry_type bim_in;
   ctr_type       gsh_in;

   tbp_tables u_tables (
      .clock  (clock),
      .reset  (reset),
      .rd_req (rd_req),
      .wr_req (wr_req),
      .rd_bim (rd_bim),
      .rd_gsh (rd_gsh),
      .busy   (busy)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_vld_ff && out_free;
   assign req_ready = !busy && (!s1_vld_ff || out_free);
   assign accept    = req_valid && req_ready;

   assign addr_idx  = req_branch_address[INDEX_BITS-1:0] & IDX_MASK;
   assign rd_req.en = accept;
   assign rd_req.bi = addr_idx;
   assign rd_req.gi = (addr_idx ^ INDEX_BITS'(hist_ff)) & IDX_MASK;

   always_comb begin
      bim_pred = rd_bim.bim;
      gsh_pred = rd_gsh[1];
      pred     = rd_bim.chooser[1] ? bim_pred : gsh_pred;
      correct  = (pred == s1_taken_ff);
      bim_in.bim     = s1_taken_ff;
      bim_in.chooser = rd_bim.chooser;
      if (bim_pred != gsh_pred) begin
         bim_in.chooser = step_ctr(rd_bim.chooser, bim_pred == s1_taken_ff);
      end
      gsh_in = step_ctr(rd_gsh, s1_taken_ff);
   end

   assign wr_req.en        = s1_adv;
   assign wr_req.bim_entry = bim_in;
   assign wr_req.gsh       = gsh_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff      <= '0;
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         hits_ff      <= '0;
         seen_ff      <= '0;
      end else begin
         if (accept) begin
            hist_ff <= hist_type'({hist_ff, req_actual_taken});
         end
         if (accept) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            rsp_valid_ff <= 1'b1;
            if (correct && hits_ff != COUNT_MAX) begin
               hits_ff <= hits_ff + count_type'(1);
            end
            if (seen_ff != COUNT_MAX) begin
               seen_ff <= seen_ff + count_type'(1);
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_taken_ff <= req_actual_taken;
      end
      if (s1_adv) begin
         pred_ff    <= pred;
         correct_ff <= correct;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_predicted_taken    = pred_ff;
   assign rsp_prediction_correct = correct_ff;
   assign rsp_correct_count      = hits_ff;
   assign rsp_branch_count       = seen_ff;

endmodule

// File: hw/rtl/tbp_tables.sv
// ----------------------------------------------------------------------------
// tbp_tables
// bimodal/chooser and gshare memories with clearing pass and write forwarding
// ----------------------------------------------------------------------------
module tbp_tables (
   input  logic                   clock,
   input  logic                   reset,
   input  tbp_pkg::rd_req_type    rd_req,
   input  tbp_pkg::wr_req_type    wr_req,
   output tbp_pkg::bim_entry_type rd_bim,
   output tbp_pkg::ctr_type       rd_gsh,
   output logic                   busy
);
   import tbp_pkg::*;

   bim_entry_type bim_mem [TABLE_ENTRIES];
   ctr_type       gsh_mem [TABLE_ENTRIES];

   bim_entry_type bim_q_ff;
   ctr_type       gsh_q_ff;
   idx_type       bi_ff;
   idx_type       gi_ff;

   logic          busy_ff;
   idx_type       clr_idx_ff;

   logic          fb_vld_ff;
   idx_type       fb_bi_ff;
   idx_type       fb_gi_ff;
   bim_entry_type fb_bim_ff;
   ctr_type       fb_gsh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff    <= 1'b1;
         clr_idx_ff <= '0;
         fb_vld_ff  <= 1'b0;
      end else begin
         if (busy_ff) begin
            if (clr_idx_ff == IDX_LAST) begin
               busy_ff <= 1'b0;
            end
            clr_idx_ff <= clr_idx_ff + idx_type'(1);
         end
         if (wr_req.en && !busy_ff) begin
            fb_vld_ff <= 1'b1;
         end
      end
   end

   // memory write port: clearing pass first, then write-back of the item
   always_ff @(posedge clock) begin
      if (busy_ff) begin
         bim_mem[clr_idx_ff] <= BIM_RESET;
         gsh_mem[clr_idx_ff] <= GSH_RESET;
      end else if (wr_req.en) begin
         bim_mem[bi_ff] <= wr_req.bim_entry;
         gsh_mem[gi_ff] <= wr_req.gsh;
      end
   end

   // memory read port and last write
   always_ff @(posedge clock) begin
      if (rd_req.en) begin
         bim_q_ff <= bim_mem[rd_req.bi];
         gsh_q_ff <= gsh_mem[rd_req.gi];
         bi_ff    <= rd_req.bi;
         gi_ff    <= rd_req.gi;
      end
      if (wr_req.en && !busy_ff) begin
         fb_bi_ff  <= bi_ff;
         fb_gi_ff  <= gi_ff;
         fb_bim_ff <= wr_req.bim_entry;
         fb_gsh_ff <= wr_req.gsh;
      end
   end

   assign rd_bim = (fb_vld_ff && fb_bi_ff == bi_ff) ? fb_bim_ff : bim_q_ff;
   assign rd_gsh = (fb_vld_ff && fb_gi_ff == gi_ff) ? fb_gsh_ff : gsh_q_ff;
   assign busy   = busy_ff;

endmodule

// File: hw/rtl/tbp_checker.sv
// ----------------------------------------------------------------------------
// tbp_checker
// port-level checks of the tournament predictor, bound to the top level
// ----------------------------------------------------------------------------
module tbp_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [31:0]          req_branch_address,
   input logic                 req_actual_taken,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic                 rsp_predicted_taken,
   input logic                 rsp_prediction_correct,
   input tbp_pkg::count_type   rsp_correct_count,
   input tbp_pkg::count_type   rsp_branch_count
);
   import tbp_pkg::*;

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_branch_address)
         && $stable(req_actual_taken))
      else $error("req word changed while waiting");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_branch_count)
         && $stable(rsp_correct_count) && $stable(rsp_predicted_taken)
         && $stable(rsp_prediction_correct))
      else $error("rsp word changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

   a_hits_le_seen: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_correct_count <= rsp_branch_count)
      else $error("correct count above branch count");

   a_seen_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_branch_count != '0)
      else $error("result word with zero branch count");

endmodule

bind tournament_branch_predictor_core tbp_checker u_tbp_checker (.*);
